### src/sbk_pkg.sv
package sbk_pkg;

  // Table size and field widths.
  localparam int TAP_SLOTS = 8;
  localparam int CNT_W     = (TAP_SLOTS > 1) ? $clog2(TAP_SLOTS) : 1;
  localparam int KEY_W     = 8;
  localparam int FRAMES_W  = 4;

  localparam logic [FRAMES_W-1:0] TAP_LEN_RESET = 4'd4;

  // Emulator key codes.
  localparam logic [KEY_W-1:0] KC_A      = 8'd1;
  localparam logic [KEY_W-1:0] KC_0      = 8'd27;
  localparam logic [KEY_W-1:0] KC_ESCAPE = 8'd59;
  localparam logic [KEY_W-1:0] KC_ENTER  = 8'd67;
  localparam logic [KEY_W-1:0] KC_SPACE  = 8'd75;
  localparam logic [KEY_W-1:0] KC_LEFT   = 8'd82;
  localparam logic [KEY_W-1:0] KC_RIGHT  = 8'd83;
  localparam logic [KEY_W-1:0] KC_UP     = 8'd84;
  localparam logic [KEY_W-1:0] KC_DOWN   = 8'd85;
  localparam logic [KEY_W-1:0] KC_LSHIFT = 8'd215;

  // Console characters.
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_H  = 8'h48;
  localparam logic [7:0] CH_UP_J  = 8'h4a;
  localparam logic [7:0] CH_UP_K  = 8'h4b;
  localparam logic [7:0] CH_UP_L  = 8'h4c;
  localparam logic [7:0] CH_UP_S  = 8'h53;
  localparam logic [7:0] CH_UP_Z  = 8'h5a;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_H  = 8'h68;
  localparam logic [7:0] CH_LO_J  = 8'h6a;
  localparam logic [7:0] CH_LO_K  = 8'h6b;
  localparam logic [7:0] CH_LO_L  = 8'h6c;
  localparam logic [7:0] CH_LO_U  = 8'h75;
  localparam logic [7:0] CH_LO_Z  = 8'h7a;

  // One slot of the tap table.
  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [FRAMES_W-1:0] frames;
  } slot_t;

  // What an input item asks for.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_TAP,
    OP_LATCH,
    OP_UNLATCH,
    OP_TICK
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHUP,
    ST_FLUSH
  } state_t;

endpackage

### src/sbk_if.sv
interface sbk_in_if
  import sbk_pkg::*;
  ();
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] byte_value;

  modport source (output valid, func, byte_value, input ready);
  modport sink (input valid, func, byte_value, output ready);
endinterface

interface sbk_out_if
  import sbk_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_code;
  logic             pressed;
  logic             last;

  modport source (output valid, key_code, pressed, last, input ready);
  modport sink (input valid, key_code, pressed, last, output ready);
endinterface

### src/sbk_cell.sv
module sbk_cell
  import sbk_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  shift_en,
  input  slot_t d,
  output slot_t q
);

  logic [KEY_W-1:0]    key_r;
  logic [FRAMES_W-1:0] frames_r;

  // The frame count marks the slot free at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r <= '0;
    end else if (shift_en) begin
      frames_r <= d.frames;
    end
  end

  // The key is only read while the slot is active.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      key_r <= d.key;
    end
  end

  assign q.key    = key_r;
  assign q.frames = frames_r;

endmodule

### src/sbk_seq.sv
module sbk_seq
  import sbk_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  sbk_in_if.sink              in_ch,
  sbk_out_if.source           out_ch,
  input  logic                cfg_we,
  input  logic [FRAMES_W-1:0] cfg_data,
  input  slot_t               head,
  output slot_t               tail,
  output logic                shift_en
);

  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] code;
    logic             shifted;
  } dec_t;

  // Maps an input item to its operation and key.
  function automatic dec_t decode(logic func, logic [7:0] c);
    dec_t d;
    d.op      = OP_NONE;
    d.code    = '0;
    d.shifted = 1'b0;
    if (func) begin
      d.op = OP_TICK;
    end else begin
      case (c)
        CH_LO_H: begin d.op = OP_TAP; d.code = KC_LEFT; end
        CH_LO_L: begin d.op = OP_TAP; d.code = KC_RIGHT; end
        CH_LO_K: begin d.op = OP_TAP; d.code = KC_UP; end
        CH_LO_J: begin d.op = OP_TAP; d.code = KC_DOWN; end
        CH_UP_H: begin d.op = OP_TAP; d.code = KC_LEFT; d.shifted = 1'b1; end
        CH_UP_L: begin d.op = OP_TAP; d.code = KC_RIGHT; d.shifted = 1'b1; end
        CH_UP_K: begin d.op = OP_TAP; d.code = KC_UP; d.shifted = 1'b1; end
        CH_UP_J: begin d.op = OP_TAP; d.code = KC_DOWN; d.shifted = 1'b1; end
        CH_UP_S: d.op = OP_LATCH;
        CH_LO_U: d.op = OP_UNLATCH;
        CH_SPACE: begin d.op = OP_TAP; d.code = KC_SPACE; end
        CH_CR: begin d.op = OP_TAP; d.code = KC_ENTER; end
        CH_LF: begin d.op = OP_TAP; d.code = KC_ENTER; end
        CH_ESC: begin d.op = OP_TAP; d.code = KC_ESCAPE; end
        default: begin
          if (c >= CH_LO_A && c <= CH_LO_Z) begin
            d.op   = OP_TAP;
            d.code = KEY_W'(KC_A + (c - CH_LO_A));
          end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            d.op      = OP_TAP;
            d.code    = KEY_W'(KC_A + (c - CH_UP_A));
            d.shifted = 1'b1;
          end else if (c >= CH_0 && c <= CH_9) begin
            d.op   = OP_TAP;
            d.code = KEY_W'(KC_0 + (c - CH_0));
          end
        end
      endcase
    end
    return d;
  endfunction

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                tick_r, tick_nxt;
  logic [KEY_W-1:0]    code_r, code_nxt;
  logic                shup_r, shup_nxt;
  logic                claimed_r, claimed_nxt;
  logic                latched_r, latched_nxt;
  logic [FRAMES_W-1:0] tap_len_r;
  logic                pend_valid_r, pend_valid_nxt;
  logic [KEY_W-1:0]    pend_code_r, pend_code_nxt;
  logic                pend_pressed_r, pend_pressed_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [KEY_W-1:0]    out_code_r, out_code_nxt;
  logic                out_pressed_r, out_pressed_nxt;
  logic                out_last_r, out_last_nxt;

  dec_t                dec;
  logic                acc;
  logic                out_free;
  logic [FRAMES_W-1:0] tap_len;
  logic                ev_rel, ev_press, scan_ev;
  logic                scan_go, shup_go, flush_go, ev_go;
  logic [KEY_W-1:0]    ev_code;
  logic                ev_pressed;
  logic                cnt_end;

  // Handshake and step conditions.
  assign dec      = decode(in_ch.func, in_ch.byte_value);
  assign in_ch.ready = (state_r == ST_IDLE);
  assign acc      = in_ch.valid && (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ch.ready;
  assign tap_len  = (tap_len_r == '0) ? FRAMES_W'(1) : tap_len_r;
  assign cnt_end  = (cnt_r == CNT_W'(TAP_SLOTS - 1));

  // The head cell releases on a tick when its count runs out, or takes a tap when free.
  assign ev_rel   = tick_r && (head.frames == FRAMES_W'(1));
  assign ev_press = !tick_r && !claimed_r && (head.frames == '0);
  assign scan_ev  = ev_rel || ev_press;
  assign scan_go  = (state_r == ST_SCAN) && !(scan_ev && pend_valid_r && !out_free);
  assign shup_go  = (state_r == ST_SHUP) && !(pend_valid_r && !out_free);
  assign flush_go = (state_r == ST_FLUSH) && (!pend_valid_r || out_free);
  assign ev_go    = (scan_go && scan_ev) || shup_go;
  assign shift_en = scan_go;

  always_comb begin
    if (state_r == ST_SHUP) begin
      ev_code    = KC_LSHIFT;
      ev_pressed = 1'b0;
    end else if (tick_r) begin
      ev_code    = head.key;
      ev_pressed = 1'b0;
    end else begin
      ev_code    = code_r;
      ev_pressed = 1'b1;
    end
  end

  // Value that re-enters the ring behind the last cell.
  always_comb begin
    tail = head;
    if (tick_r) begin
      if (head.frames != '0) begin
        tail.frames = head.frames - FRAMES_W'(1);
      end
    end else if (ev_press) begin
      tail.key    = code_r;
      tail.frames = tap_len;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (dec.op == OP_TICK || dec.op == OP_TAP) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_SCAN: begin
        if (scan_go && cnt_end) begin
          state_nxt = shup_r ? ST_SHUP : ST_FLUSH;
        end
      end
      ST_SHUP: begin
        if (shup_go) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (flush_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath: one event waits in the pending stage until the next one shows
  // whether it is the last of its item.
  always_comb begin
    cnt_nxt          = cnt_r;
    tick_nxt         = tick_r;
    code_nxt         = code_r;
    shup_nxt         = shup_r;
    claimed_nxt      = claimed_r;
    latched_nxt      = latched_r;
    pend_valid_nxt   = pend_valid_r;
    pend_code_nxt    = pend_code_r;
    pend_pressed_nxt = pend_pressed_r;
    out_valid_nxt    = out_ch.ready ? 1'b0 : out_valid_r;
    out_code_nxt     = out_code_r;
    out_pressed_nxt  = out_pressed_r;
    out_last_nxt     = out_last_r;

    if (acc) begin
      tick_nxt         = (dec.op == OP_TICK);
      code_nxt         = dec.code;
      shup_nxt         = dec.shifted;
      claimed_nxt      = 1'b0;
      cnt_nxt          = '0;
      pend_code_nxt    = KC_LSHIFT;
      pend_pressed_nxt = (dec.op != OP_UNLATCH);
      pend_valid_nxt   = dec.shifted || (dec.op == OP_LATCH && !latched_r) ||
                         (dec.op == OP_UNLATCH && latched_r);
      if (dec.op == OP_LATCH) begin
        latched_nxt = 1'b1;
      end else if (dec.op == OP_UNLATCH) begin
        latched_nxt = 1'b0;
      end
    end

    if (scan_go) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      if (ev_press) begin
        claimed_nxt = 1'b1;
      end
    end

    if (ev_go) begin
      if (pend_valid_r) begin
        out_valid_nxt   = 1'b1;
        out_code_nxt    = pend_code_r;
        out_pressed_nxt = pend_pressed_r;
        out_last_nxt    = 1'b0;
      end
      pend_valid_nxt   = 1'b1;
      pend_code_nxt    = ev_code;
      pend_pressed_nxt = ev_pressed;
    end

    if (flush_go && pend_valid_r) begin
      out_valid_nxt   = 1'b1;
      out_code_nxt    = pend_code_r;
      out_pressed_nxt = pend_pressed_r;
      out_last_nxt    = 1'b1;
      pend_valid_nxt  = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      latched_r    <= 1'b0;
      tap_len_r    <= TAP_LEN_RESET;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      latched_r    <= latched_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        tap_len_r <= cfg_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cnt_r          <= cnt_nxt;
    tick_r         <= tick_nxt;
    code_r         <= code_nxt;
    shup_r         <= shup_nxt;
    claimed_r      <= claimed_nxt;
    pend_code_r    <= pend_code_nxt;
    pend_pressed_r <= pend_pressed_nxt;
    out_code_r     <= out_code_nxt;
    out_pressed_r  <= out_pressed_nxt;
    out_last_r     <= out_last_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.key_code = out_code_r;
  assign out_ch.pressed  = out_pressed_r;
  assign out_ch.last     = out_last_r;

endmodule

### src/serial_byte_key_tap_injector.sv
// Each byte is worked on to the end before the next is taken. A byte that taps no key only
// flushes; a tap or a tick first makes one full turn of the slot ring, then a shifted tap
// releases shift. Output stalls hold the ring once the one-event holding stage is full.
// Reset (synchronous, active low) frees every slot, clears the shift latch and sets the
// tap length to 4; slot keys are not cleared.
module serial_byte_key_tap_injector
  import sbk_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  sbk_in_if.sink              in_ch,
  sbk_out_if.source           out_ch,
  input  logic                cfg_we,
  input  logic [FRAMES_W-1:0] cfg_data
);

  slot_t ring [TAP_SLOTS];
  slot_t tail;
  logic  shift_en;

  // Slot table as a ring: every step moves each slot one cell towards the head.
  for (genvar i = 0; i < TAP_SLOTS; i++) begin : g_cell
    slot_t d_in;
    if (i == TAP_SLOTS - 1) begin : g_end
      assign d_in = tail;
    end else begin : g_mid
      assign d_in = ring[i+1];
    end
    sbk_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .d        (d_in),
      .q        (ring[i])
    );
  end

  // Sequencer at the head of the ring.
  sbk_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .head     (ring[0]),
    .tail     (tail),
    .shift_en (shift_en)
  );

  // The ring only turns while an item is being worked on.
  a_no_turn_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    shift_en |-> !in_ch.ready)
    else $error("slot ring turned while the block was ready for input");

  // Every input transfer leaves the block busy in the following cycle.
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("block ready again straight after an input transfer");

  // The block only leaves idle because an item was taken.
  a_busy_only_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ch.ready) |-> $past(in_ch.valid))
    else $error("block went busy without an input transfer");

endmodule
